// File: sv/rek_pkg.sv
// rek_pkg: shared types and constants for the rotary encoder and key qualifier.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package rek_pkg;

  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_ROTATE_SETTLE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STUCK_LIMIT   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_SETTLE    = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS    = 8'd3;

  localparam logic [7:0]  ROTATE_SETTLE_RST = 8'd3;
  localparam logic [15:0] STUCK_LIMIT_RST   = 16'd1000;
  localparam logic [7:0]  KEY_SETTLE_RST    = 8'd10;
  localparam logic [15:0] LONG_PRESS_RST    = 16'd2000;

  localparam logic [1:0] ROT_EV_NONE  = 2'd0;
  localparam logic [1:0] ROT_EV_RIGHT = 2'd1;
  localparam logic [1:0] ROT_EV_LEFT  = 2'd2;

  localparam logic [1:0] KEY_EV_NONE  = 2'd0;
  localparam logic [1:0] KEY_EV_SHORT = 2'd1;
  localparam logic [1:0] KEY_EV_LONG  = 2'd2;

  typedef enum logic [1:0] {
    ROT_IDLE   = 2'd0,
    ROT_SETTLE = 2'd1,
    ROT_HELD   = 2'd2
  } rot_phase_t;

  typedef enum logic [1:0] {
    KEY_IDLE    = 2'd0,
    KEY_SETTLE  = 2'd1,
    KEY_HELD    = 2'd2,
    KEY_LATCHED = 2'd3
  } key_phase_t;

  typedef struct packed {
    logic pin_a;
    logic pin_b;
    logic pin_key;
  } rek_in_t;

  typedef struct packed {
    logic [1:0] rotate_event;
    logic [1:0] key_event;
  } rek_out_t;

  typedef struct packed {
    logic [7:0]  settle_ticks;
    logic [15:0] stuck_ticks;
  } rek_rot_cfg_t;

  typedef struct packed {
    logic [7:0]  settle_ticks;
    logic [15:0] long_ticks;
  } rek_key_cfg_t;

endpackage

`default_nettype wire

// File: sv/rek_rotary.sv
// rek_rotary: encoder channel A/B phase tracker, one tick per step_en.
// Depends on rek_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rek_rotary (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  step_en,
  input  wire logic                  pin_a,
  input  wire logic                  pin_b,
  input  wire rek_pkg::rek_rot_cfg_t cfg,
  output logic [1:0]                 rotate_event
);
  import rek_pkg::*;

  rot_phase_t  phase_r, phase_nxt;
  logic        latched_b_r, latched_b_nxt;
  logic [15:0] timer_r, timer_nxt;
  logic [15:0] timer_inc;
  logic [15:0] settle_lim, stuck_lim;

  // a limit of zero behaves as one
  assign settle_lim = (cfg.settle_ticks == 8'd0) ? 16'd1 : {8'd0, cfg.settle_ticks};
  assign stuck_lim  = (cfg.stuck_ticks == 16'd0) ? 16'd1 : cfg.stuck_ticks;
  assign timer_inc  = timer_r + 16'd1;

  always_comb begin
    phase_nxt     = phase_r;
    latched_b_nxt = latched_b_r;
    timer_nxt     = timer_r;
    rotate_event  = ROT_EV_NONE;
    case (phase_r)
      ROT_IDLE: begin
        if (!pin_a) begin
          latched_b_nxt = pin_b;
          timer_nxt     = 16'd0;
          phase_nxt     = ROT_SETTLE;
        end
      end
      ROT_SETTLE: begin
        if (pin_a) begin
          phase_nxt = ROT_IDLE;
        end else if (timer_inc >= settle_lim) begin
          timer_nxt = 16'd0;
          phase_nxt = ROT_HELD;
        end else begin
          timer_nxt = timer_inc;
        end
      end
      default: begin
        if (pin_a) begin
          rotate_event = latched_b_r ? ROT_EV_LEFT : ROT_EV_RIGHT;
          phase_nxt    = ROT_IDLE;
        end else if (timer_inc >= stuck_lim) begin
          // held too long: drop the turn
          timer_nxt = 16'd0;
          phase_nxt = ROT_IDLE;
        end else begin
          timer_nxt = timer_inc;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= ROT_IDLE;
      latched_b_r <= 1'b0;
      timer_r     <= 16'd0;
    end else if (step_en) begin
      phase_r     <= phase_nxt;
      latched_b_r <= latched_b_nxt;
      timer_r     <= timer_nxt;
    end
  end

endmodule

`default_nettype wire

// File: sv/rek_key.sv
// rek_key: push-key debounce and short/long press detection, one tick per step_en.
// Depends on rek_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rek_key (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  step_en,
  input  wire logic                  pin_key,
  input  wire rek_pkg::rek_key_cfg_t cfg,
  output logic [1:0]                 key_event
);
  import rek_pkg::*;

  key_phase_t  phase_r, phase_nxt;
  logic [15:0] timer_r, timer_nxt;
  logic [15:0] timer_inc;
  logic [15:0] settle_lim, long_lim;

  assign settle_lim = (cfg.settle_ticks == 8'd0) ? 16'd1 : {8'd0, cfg.settle_ticks};
  assign long_lim   = (cfg.long_ticks == 16'd0) ? 16'd1 : cfg.long_ticks;
  assign timer_inc  = timer_r + 16'd1;

  always_comb begin
    phase_nxt = phase_r;
    timer_nxt = timer_r;
    key_event = KEY_EV_NONE;
    case (phase_r)
      KEY_IDLE: begin
        if (!pin_key) begin
          timer_nxt = 16'd0;
          phase_nxt = KEY_SETTLE;
        end
      end
      KEY_SETTLE: begin
        if (pin_key) begin
          phase_nxt = KEY_IDLE;
        end else if (timer_inc >= settle_lim) begin
          timer_nxt = 16'd0;
          phase_nxt = KEY_HELD;
        end else begin
          timer_nxt = timer_inc;
        end
      end
      KEY_HELD: begin
        if (pin_key) begin
          key_event = KEY_EV_SHORT;
          phase_nxt = KEY_IDLE;
        end else if (timer_inc >= long_lim) begin
          key_event = KEY_EV_LONG;
          timer_nxt = 16'd0;
          phase_nxt = KEY_LATCHED;
        end else begin
          timer_nxt = timer_inc;
        end
      end
      default: begin
        // long press reported; wait for release
        if (pin_key) begin
          phase_nxt = KEY_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= KEY_IDLE;
      timer_r <= 16'd0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      timer_r <= timer_nxt;
    end
  end

endmodule

`default_nettype wire

// File: sv/rotary_encoder_key_qualifier.sv
// rotary_encoder_key_qualifier: top level; input register, config registers,
// rotation and key trackers, result register. Depends on rek_pkg, rek_rotary, rek_key.
//
//   channel | direction | payload    | handshake
//   in_     | input     | rek_in_t   | in_valid / in_stall
//   out_    | output    | rek_out_t  | out_valid / out_stall
//   cfg_    | input     | 16b data   | cfg_wr_en, cfg_index
//
// One beat in, one beat out; throughput one beat per cycle while out_stall is low.
// A beat passes through the input register, then the tracker logic into the result register.
// The trackers advance when a beat moves from the input register to the result register.
// in_stall rises only when both registers hold beats and out_stall is high.
// rst_n is synchronous; it clears valids, tracker phases and loads config defaults.
`timescale 1ns / 1ps
`default_nettype none

module rotary_encoder_key_qualifier (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire rek_pkg::rek_in_t                  in_data,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output rek_pkg::rek_out_t                      out_data,
  input  wire logic                              cfg_wr_en,
  input  wire logic [rek_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [rek_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import rek_pkg::*;

  logic         in_valid_r;
  rek_in_t      in_data_r;
  logic         out_valid_r;
  rek_out_t     out_data_r;
  logic         advance;
  logic         step_en;
  rek_out_t     result;
  logic [1:0]   rot_event;
  logic [1:0]   key_event;

  logic [7:0]   rotate_settle_r;
  logic [15:0]  stuck_limit_r;
  logic [7:0]   key_settle_r;
  logic [15:0]  long_press_r;
  rek_rot_cfg_t rot_cfg;
  rek_key_cfg_t key_cfg;

  assign advance  = !out_valid_r || !out_stall;
  assign step_en  = in_valid_r && advance;
  assign in_stall = in_valid_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rotate_settle_r <= ROTATE_SETTLE_RST;
      stuck_limit_r   <= STUCK_LIMIT_RST;
      key_settle_r    <= KEY_SETTLE_RST;
      long_press_r    <= LONG_PRESS_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_ROTATE_SETTLE: rotate_settle_r <= cfg_wdata[7:0];
        CFG_STUCK_LIMIT:   stuck_limit_r   <= cfg_wdata;
        CFG_KEY_SETTLE:    key_settle_r    <= cfg_wdata[7:0];
        CFG_LONG_PRESS:    long_press_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign rot_cfg = '{settle_ticks: rotate_settle_r, stuck_ticks: stuck_limit_r};
  assign key_cfg = '{settle_ticks: key_settle_r, long_ticks: long_press_r};

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_data_r <= in_data;
    end
  end

  rek_rotary u_rotary (
    .clk          (clk),
    .rst_n        (rst_n),
    .step_en      (step_en),
    .pin_a        (in_data_r.pin_a),
    .pin_b        (in_data_r.pin_b),
    .cfg          (rot_cfg),
    .rotate_event (rot_event)
  );

  rek_key u_key (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (step_en),
    .pin_key   (in_data_r.pin_key),
    .cfg       (key_cfg),
    .key_event (key_event)
  );

  assign result = '{rotate_event: rot_event, key_event: key_event};

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire
